/* rtl/hbf_pkg.sv */
// shared types and constants for the height map box filter
`default_nettype none
package hbf_pkg;

  localparam int unsigned SIZE_W = 13;
  localparam int unsigned POS_W = 13;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MAG_W = 28;
  localparam int unsigned DIVC_W = 5;

  localparam logic [1:0] REG_FRAME_WIDTH = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;
  localparam logic [1:0] REG_HEIGHT_OFFSET = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_DIVL,
    ST_DIV,
    ST_FIN,
    ST_POS
  } state_t;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic signed [15:0] height_scale;
    logic signed [23:0] height_offset;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic shift;
    logic sum_ld;
    logic mul_ld;
    logic div_ld;
    logic fin_ld;
    logic pos_upd;
    logic rsel;
    logic csel;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic any;
    logic rstart;
    logic rend;
    logic cstart;
    logic cend;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/heightmap_box_filter_3x3.sv */
// top level: register port, controller and datapath of the height map box filter
`default_nettype none
// Streaming 3x3 box filter over a raster height map. Each byte word is read and
// shifted into the window. Each result it completes then takes a window sum, one
// 13x16 multiply, then a 28-step restoring divider by the neighbour count. A word
// completes up to four results at the last column and row, and a stalled output
// holds each one back until it is taken. Two line
// stores of MAX_WIDTH bytes hold the previous rows; they need no clearing, as data
// outside the frame is never used. Registers: frame_width at 0x0, frame_height at
// 0x4, height_scale at 0x8, height_offset at 0xC; write them only while idle.
module heightmap_box_filter_3x3
  import hbf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         raw_height,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      filtered_height,
  output logic [11:0]             out_row,
  output logic [11:0]             out_col,
  output logic                    run_last,
  output logic                    frame_done
);

  cfg_t cfg;
  cmd_t cmd;
  stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= 13'd256;
      cfg.frame_height <= 13'd256;
      cfg.height_scale <= 16'sd256;
      cfg.height_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH: cfg.frame_width <= pwdata[12:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[12:0];
        REG_HEIGHT_SCALE: cfg.height_scale <= pwdata[15:0];
        REG_HEIGHT_OFFSET: cfg.height_offset <= pwdata[23:0];
        default: cfg.frame_width <= cfg.frame_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH: prdata = {19'd0, cfg.frame_width};
      REG_FRAME_HEIGHT: prdata = {19'd0, cfg.frame_height};
      REG_HEIGHT_SCALE: prdata = {16'd0, cfg.height_scale};
      REG_HEIGHT_OFFSET: prdata = {8'd0, cfg.height_offset};
      default: prdata = '0;
    endcase
  end

  hbf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  hbf_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .stat(stat),
    .raw_height(raw_height), .out_valid(out_valid), .out_stall(out_stall),
    .filtered_height(filtered_height), .out_row(out_row), .out_col(out_col),
    .run_last(run_last), .frame_done(frame_done)
  );

endmodule
`default_nettype wire

/* rtl/hbf_ram.sv */
// generic single-write, single-read ram with registered read
`default_nettype none
module hbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/hbf_ctrl.sv */
// controller: sequences one word through read, window update and the results
`default_nettype none
module hbf_ctrl
  import hbf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic rsel, rsel_next;
  logic csel, csel_next;
  logic last;

  assign last = (rsel == stat.rend) && (csel == stat.cend);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsel <= 1'b0;
      csel <= 1'b0;
    end else begin
      state <= state_next;
      rsel <= rsel_next;
      csel <= csel_next;
    end
  end

  always_comb begin
    state_next = state;
    rsel_next = rsel;
    csel_next = csel;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RD;
      end
      ST_RD: state_next = ST_SHIFT;
      ST_SHIFT: begin
        rsel_next = stat.rstart;
        csel_next = stat.cstart;
        state_next = stat.any ? ST_SUM : ST_POS;
      end
      ST_SUM: state_next = ST_MUL;
      ST_MUL: state_next = ST_DIVL;
      ST_DIVL: state_next = ST_DIV;
      ST_DIV: begin
        if (!stat.div_busy) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          if (last) begin
            state_next = ST_POS;
          end else begin
            state_next = ST_SUM;
            if (csel != stat.cend) begin
              csel_next = 1'b1;
            end else begin
              csel_next = stat.cstart;
              rsel_next = 1'b1;
            end
          end
        end
      end
      ST_POS: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rsel = rsel;
    cmd.csel = csel;
    cmd.last = last;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: cmd.accept = in_valid;
      ST_SHIFT: cmd.shift = 1'b1;
      ST_SUM: cmd.sum_ld = 1'b1;
      ST_MUL: cmd.mul_ld = 1'b1;
      ST_DIVL: cmd.div_ld = 1'b1;
      ST_FIN: cmd.fin_ld = stat.out_free;
      ST_POS: cmd.pos_upd = 1'b1;
      default: cmd.accept = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/hbf_dp.sv */
// datapath: line stores, window, sum, multiply, divider and output register
`default_nettype none
module hbf_dp
  import hbf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  input  wire logic [7:0]           raw_height,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [23:0]        filtered_height,
  output logic [11:0]               out_row,
  output logic [11:0]               out_col,
  output logic                      run_last,
  output logic                      frame_done
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [SIZE_W-1:0] WLIM = (MAX_WIDTH > 8191) ? 13'd8191 : SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HLIM = (MAX_HEIGHT > 8191) ? 13'd8191 : SIZE_W'(MAX_HEIGHT);

  logic [SIZE_W-1:0] w, h;
  logic [POS_W-1:0] cpos, rpos, cclamp, rclamp;
  logic [7:0] px;
  logic [7:0] win [9];
  logic [7:0] prev_rd, prev2_rd;
  logic [AW-1:0] addr;

  logic [11:0] sum, sum_next;
  logic [3:0] cnt, cnt_next;
  logic [2:0] rm, cm;
  logic signed [28:0] prod;
  logic neg;
  logic [MAG_W-1:0] dvd;
  logic [3:0] rem;
  logic [4:0] trial;
  logic [DIVC_W-1:0] divc;
  logic signed [28:0] quo_s;
  logic signed [29:0] vsum;
  logic signed [23:0] vsat;
  logic [POS_W-1:0] crow, ccol;

  always_comb begin
    w = (cfg.frame_width == '0) ? 13'd1 :
        ((cfg.frame_width > WLIM) ? WLIM : cfg.frame_width);
    h = (cfg.frame_height == '0) ? 13'd1 :
        ((cfg.frame_height > HLIM) ? HLIM : cfg.frame_height);
    cclamp = (cpos >= w) ? w - 13'd1 : cpos;
    rclamp = (rpos >= h) ? h - 13'd1 : rpos;
  end

  assign addr = AW'(cpos);

  hbf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prev (
    .clk(clk), .we(cmd.shift), .waddr(addr), .wdata(px), .raddr(addr), .rdata(prev_rd)
  );

  hbf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_prev2 (
    .clk(clk), .we(cmd.shift), .waddr(addr), .wdata(prev_rd), .raddr(addr),
    .rdata(prev2_rd)
  );

  // positions, clamped when the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      cpos <= '0;
      rpos <= '0;
    end else if (cmd.accept) begin
      cpos <= cclamp;
      rpos <= rclamp;
    end else if (cmd.pos_upd) begin
      if (cpos == w - 13'd1) begin
        cpos <= '0;
        rpos <= (rpos == h - 13'd1) ? '0 : rpos + 13'd1;
      end else begin
        cpos <= cpos + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) px <= raw_height;
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3] <= win[i*3+1];
        win[i*3+1] <= win[i*3+2];
      end
      win[2] <= prev2_rd;
      win[5] <= prev_rd;
      win[8] <= px;
    end
  end

  always_comb begin
    stat.rstart = (rpos == '0);
    stat.rend = (rpos == h - 13'd1);
    stat.cstart = (cpos == '0);
    stat.cend = (cpos == w - 13'd1);
    stat.any = (!stat.rstart || stat.rend) && (!stat.cstart || stat.cend);
    stat.div_busy = (divc != '0);
    stat.out_free = !out_valid || !out_stall;
  end

  // in-bounds masks over the window rows and columns
  always_comb begin
    rm = cmd.rsel ? {1'b1, (rpos >= 13'd1), 1'b0} : {2'b11, (rpos >= 13'd2)};
    cm = cmd.csel ? {1'b1, (cpos >= 13'd1), 1'b0} : {2'b11, (cpos >= 13'd2)};
    sum_next = '0;
    cnt_next = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (rm[i] && cm[j]) begin
          sum_next = sum_next + {4'd0, win[i*3+j]};
          cnt_next = cnt_next + 4'd1;
        end
      end
    end
    crow = cmd.rsel ? rpos : rpos - 13'd1;
    ccol = cmd.csel ? cpos : cpos - 13'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_ld) begin
      sum <= sum_next;
      cnt <= cnt_next;
    end
    if (cmd.mul_ld) prod <= $signed({1'b0, sum}) * cfg.height_scale;
  end

  // restoring divider, one quotient bit a cycle
  assign trial = {rem, dvd[MAG_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      divc <= '0;
    end else if (cmd.div_ld) begin
      divc <= DIVC_W'(MAG_W);
    end else if (divc != '0) begin
      divc <= divc - 5'd1;
    end
    if (cmd.div_ld) begin
      neg <= prod[28];
      dvd <= prod[28] ? MAG_W'(-prod) : MAG_W'(prod);
      rem <= '0;
    end else if (divc != '0) begin
      if (trial >= {1'b0, cnt}) begin
        rem <= 4'(trial - {1'b0, cnt});
        dvd <= {dvd[MAG_W-2:0], 1'b1};
      end else begin
        rem <= trial[3:0];
        dvd <= {dvd[MAG_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    quo_s = $signed({1'b0, dvd}) + ((neg && rem != '0) ? 29'sd1 : 29'sd0);
    if (neg) quo_s = -quo_s;
    vsum = 30'(quo_s) + 30'(cfg.height_offset);
    if (vsum > 30'sd8388607) begin
      vsat = 24'sh7fffff;
    end else if (vsum < -30'sd8388608) begin
      vsat = 24'sh800000;
    end else begin
      vsat = vsum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.fin_ld) begin
      filtered_height <= vsat;
      out_row <= crow[11:0];
      out_col <= ccol[11:0];
      run_last <= cmd.last;
      frame_done <= cmd.rsel && cmd.csel;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> run_last)
    else $error("frame end word not marked last");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.sum_ld) |-> (cnt >= 4'd1 && cnt <= 4'd9))
    else $error("neighbour count out of range");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    $fell(stat.div_busy) |-> (rem < cnt))
    else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

/* tb/sv/hbf_checker.sv */
// checker for the height map box filter: predicts filtered heights and compares results
module hbf_checker
  import hbf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [7:0]         raw_height,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [23:0] filtered_height,
  input  wire logic [11:0]        out_row,
  input  wire logic [11:0]        out_col,
  input  wire logic               run_last,
  input  wire logic               frame_done,
  output int                      pending,
  output int                      failures
);

  typedef struct packed {
    logic signed [23:0] height;
    logic [11:0]        row;
    logic [11:0]        col;
    logic               last;
    logic               done;
  } height_res_t;

  height_res_t  expected_heights[$];
  logic [7:0]   prev_line[4096];
  logic [7:0]   prev2_line[4096];
  logic [7:0]   win[9];
  int           col_pos;
  int           row_pos;
  logic [12:0]  cfg_width;
  logic [12:0]  cfg_height;
  logic signed [15:0] cfg_scale;
  logic signed [23:0] cfg_offset;

  assign pending = expected_heights.size();

  function automatic int clamp_dim(logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return int'(v);
  endfunction

  function automatic logic signed [23:0] box_mean(int cr, int cc, int r, int c, int w, int h);
    longint sum, cnt, p, q, v;
    int y, x, wi, wj;
    sum = 0;
    cnt = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        y = cr + dy;
        x = cc + dx;
        wi = y - (r - 2);
        wj = x - (c - 2);
        if (y >= 0 && y < h && x >= 0 && x < w && wi >= 0 && wi <= 2 && wj >= 0 && wj <= 2)
        begin
          sum += win[wi * 3 + wj];
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    p = sum * longint'(cfg_scale);
    q = p / cnt;
    if (p % cnt != 0 && p < 0) q--;
    v = q + longint'(cfg_offset);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic predict_filtered_heights(logic [7:0] px);
    int w, h, r, c, nr, nc, n;
    int rows[2];
    int cols[2];
    height_res_t res;
    w = clamp_dim(cfg_width);
    h = clamp_dim(cfg_height);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    nr = 0;
    nc = 0;
    n = 0;
    for (int i = 0; i < 3; i++) begin
      win[i * 3] = win[i * 3 + 1];
      win[i * 3 + 1] = win[i * 3 + 2];
    end
    win[2] = prev2_line[c];
    win[5] = prev_line[c];
    win[8] = px;
    prev2_line[c] = prev_line[c];
    prev_line[c] = px;
    if (r >= 1) rows[nr++] = r - 1;
    if (r == h - 1) rows[nr++] = r;
    if (c >= 1) cols[nc++] = c - 1;
    if (c == w - 1) cols[nc++] = c;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        res.height = box_mean(rows[i], cols[j], r, c, w, h);
        res.row = rows[i][11:0];
        res.col = cols[j][11:0];
        res.last = (i == nr - 1) && (j == nc - 1);
        res.done = (rows[i] == h - 1) && (cols[j] == w - 1);
        expected_heights.push_back(res);
      end
    end
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    height_res_t e;
    if (rst) begin
      failures = 0;
      expected_heights.delete();
      for (int i = 0; i < 9; i++) win[i] = 8'd0;
      for (int i = 0; i < 4096; i++) begin
        prev_line[i] = 8'd0;
        prev2_line[i] = 8'd0;
      end
      col_pos = 0;
      row_pos = 0;
      cfg_width = 13'd256;
      cfg_height = 13'd256;
      cfg_scale = 16'sd256;
      cfg_offset = 24'sd0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_heights.size() == 0) begin
          $display("%0t: unexpected word: height %0d row %0d col %0d", $time,
                   filtered_height, out_row, out_col);
          failures++;
        end else begin
          e = expected_heights.pop_front();
          if (e.height !== filtered_height || e.row !== out_row || e.col !== out_col ||
              e.last !== run_last || e.done !== frame_done) begin
            $display("%0t: mismatch exp h=%0d r=%0d c=%0d last=%0b done=%0b", $time,
                     e.height, e.row, e.col, e.last, e.done);
            $display("%0t:          got h=%0d r=%0d c=%0d last=%0b done=%0b", $time,
                     filtered_height, out_row, out_col, run_last, frame_done);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) predict_filtered_heights(raw_height);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FRAME_WIDTH: cfg_width = pwdata[12:0];
          REG_FRAME_HEIGHT: cfg_height = pwdata[12:0];
          REG_HEIGHT_SCALE: cfg_scale = pwdata[15:0];
          REG_HEIGHT_OFFSET: cfg_offset = pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// top of the height map box filter testbench: stimulus, register setup and verdict
module tb_top;
  import hbf_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         raw_height = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] filtered_height;
  logic [11:0]        out_row;
  logic [11:0]        out_col;
  logic               run_last;
  logic               frame_done;
  int                 pending;
  int                 failures;
  int                 cycles = 0;
  int                 words_sent = 0;
  bit                 quiet = 1'b0;
  bit                 hold_go = 1'b0;

  heightmap_box_filter_3x3 i_dut (.*);
  hbf_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int scale, int offset);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
    reg_write(REG_HEIGHT_SCALE, scale);
    reg_write(REG_HEIGHT_OFFSET, offset);
  endtask

  task automatic send_word(logic [7:0] v);
    in_valid <= 1'b1;
    raw_height <= v;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    words_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // kind 0 random, 1 all max, 2 all zero
  task automatic send_words(int n, int kind);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      case (kind)
        1: v = 8'hff;
        2: v = 8'h00;
        default: begin
          v = $urandom_range(0, 255);
          if ($urandom_range(0, 7) == 0) v = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        end
      endcase
      send_word(v);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (!quiet) begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (700) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  initial begin
    int w, h;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // saturation high, then low, then an all-zero row, on small frames
    set_frame(3, 3, 32'h7fff, 32'h7fffff);
    send_words(9, 1);
    set_frame(0, 2, 32'h8000, 32'h800000);
    send_words(2, 1);
    set_frame(5, 1, 32'h0100, 0);
    send_words(5, 2);
    // width shrinks mid-frame: position lands past the last column
    set_frame(4, 4, 32'hff80, 32'h001234);
    send_words(6, 0);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 2);
    send_words(5, 0);
    // random frames
    while (words_sent < 45) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 4);
      if ($urandom_range(0, 5) == 0) w = 0;
      if ($urandom_range(0, 5) == 0) h = 0;
      set_frame(w, h, $urandom, $urandom);
      send_words((w == 0 ? 1 : w) * (h == 0 ? 1 : h), 0);
    end
    // long receiver hold while words keep coming
    set_frame(6, 4, $urandom, $urandom);
    hold_go = 1'b1;
    send_words(24, 0);
    // widest and tallest frames, oversize register values, cut short by shrinking
    set_frame(13'h1fff, 1, $urandom, $urandom);
    send_words(6, 0);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 3);
    send_words(1, 0);
    set_frame(1, 13'h1fff, $urandom, $urandom);
    send_words(6, 0);
    wait_idle();
    reg_write(REG_FRAME_HEIGHT, 4);
    send_words(1, 0);
    set_frame(4096, 2, $urandom, $urandom);
    send_words(8, 0);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, 4);
    send_words(4, 0);
    quiet = 1'b1;
    set_frame(7, 5, $urandom, $urandom);
    send_words(35, 0);
    wait_idle();
    if (failures == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
